@@ design/i2cm_pkg.sv @@
package i2cm_pkg;

    localparam int unsigned ACK_TIMEOUT_RESET = 1024;
    localparam int unsigned QUEUE_DEPTH       = 2;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_DATA  = 2'd3
    } t_opcode;

    // one classified beat handed from front to back
    typedef struct packed {
        t_opcode    op;
        logic [6:0] dev_addr;
        logic [7:0] sub_addr;
        logic [7:0] length;
        logic       use_reg;
        logic [7:0] data_byte;
        logic       sda_in;
    } t_cmd;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       want_data;
        logic       done_ok;
        logic       failed;
        logic       busy;
    } t_res;

    localparam int unsigned CMD_W = $bits(t_cmd);
    localparam int unsigned RES_W = $bits(t_res);

endpackage

@@ design/i2cm_queue.sv @@
module i2cm_queue import i2cm_pkg::*; #(
    parameter int unsigned WIDTH = CMD_W,
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_valid,
    output logic             o_wr_ready,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             o_rd_valid,
    input  logic             i_rd_ready,
    output logic [WIDTH-1:0] o_rd_data
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;
    logic             wr, rd;

    assign o_wr_ready = (r_cnt != AW'(0) + (AW+1)'(DEPTH));
    assign o_rd_valid = (r_cnt != '0);
    assign o_rd_data  = r_mem[r_rp];
    assign wr = i_wr_valid && o_wr_ready;
    assign rd = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_wr_data;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end
endmodule

@@ design/i2cm_front.sv @@
module i2cm_front import i2cm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [39:0] i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_cmd        o_cmd
);
    // unpack the input beat into named fields
    t_cmd  cmd;
    assign cmd.op        = t_opcode'(i_data[1:0]);
    assign cmd.dev_addr  = i_data[8:2];
    assign cmd.sub_addr  = i_data[16:9];
    assign cmd.length    = i_data[24:17];
    assign cmd.use_reg   = i_data[25];
    assign cmd.data_byte = i_data[33:26];
    assign cmd.sda_in    = i_data[34];

    // register stage in front of the queue
    logic r_valid;
    t_cmd r_cmd;
    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_cmd <= cmd;
        end
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end
endmodule

@@ design/i2cm_back.sv @@
module i2cm_back import i2cm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_cmd        i_cmd,
    output logic        o_valid,
    input  logic        i_ready,
    output t_res        o_res
);
    typedef enum logic [2:0] {
        B_IDLE, B_START, B_TX, B_ACK, B_WAIT, B_RX, B_RXACK, B_STOP
    } t_base;
    typedef enum logic [1:0] {
        K_ADDRW, K_REG, K_ADDRR, K_DATA
    } t_kind;

    logic [15:0] r_timeout;
    t_base       r_base, n_base;
    t_kind       r_kind, n_kind;
    logic [1:0]  r_sub, n_sub;
    logic [3:0]  r_bits, n_bits;
    logic [7:0]  r_shift, n_shift, r_left, n_left;
    logic [15:0] r_timer, n_timer;
    logic [6:0]  r_dev, n_dev;
    logic [7:0]  r_reg, n_reg;
    logic [1:0]  r_mode, n_mode;
    logic [8:0]  r_pend, n_pend;
    logic        r_scl, n_scl, r_sda, n_sda;
    logic        r_ovalid;
    t_res        r_res, n_res;
    logic        take;
    logic [15:0] timer_inc;
    logic [7:0]  left_dec;

    assign o_ready = !r_ovalid || i_ready;
    assign take    = i_valid && o_ready;
    assign o_valid = r_ovalid;
    assign o_res   = r_res;
    assign timer_inc = r_timer + 16'd1;
    assign left_dec  = r_left - 8'd1;

    // one bus phase per tick
    always_comb begin
        n_base = r_base; n_kind = r_kind; n_sub = r_sub; n_bits = r_bits;
        n_shift = r_shift; n_left = r_left; n_timer = r_timer; n_dev = r_dev;
        n_reg = r_reg; n_mode = r_mode; n_pend = r_pend;
        n_scl = r_scl; n_sda = r_sda;
        n_res = '0;
        case (i_cmd.op)
            OP_WRITE, OP_READ: begin
                if (r_base == B_IDLE) begin
                    n_dev = i_cmd.dev_addr;
                    n_reg = i_cmd.sub_addr;
                    if (i_cmd.op == OP_READ) begin
                        n_mode = {i_cmd.use_reg, 1'b1};
                        n_left = (i_cmd.length == 8'd0) ? 8'd1 : i_cmd.length;
                    end else begin
                        n_mode = 2'b00;
                        n_left = i_cmd.length;
                    end
                    n_pend = '0;
                    n_base = B_START; n_kind = K_ADDRW; n_sub = 2'd1;
                end
            end
            OP_DATA: begin
                if (r_base == B_WAIT && !r_pend[8]) begin
                    n_pend = {1'b1, i_cmd.data_byte};
                end
            end
            default: begin
                case (r_base)
                    B_START: begin
                        case (r_sub)
                            2'd0: begin n_scl = 1'b0; n_sda = 1'b1; n_sub = 2'd1; end
                            2'd1: begin n_scl = 1'b1; n_sda = 1'b1; n_sub = 2'd2; end
                            2'd2: begin n_scl = 1'b1; n_sda = 1'b0; n_sub = 2'd3; end
                            default: begin
                                n_scl = 1'b0; n_sda = 1'b0;
                                n_base = B_TX; n_sub = 2'd0; n_bits = '0;
                                if (r_kind == K_REG || r_mode == 2'b01) begin
                                    n_kind = K_ADDRR; n_shift = {r_dev, 1'b1};
                                end else begin
                                    n_kind = K_ADDRW; n_shift = {r_dev, 1'b0};
                                end
                            end
                        endcase
                    end
                    B_TX: begin
                        n_sda = r_shift[7];
                        if (r_sub == 2'd0) begin
                            n_scl = 1'b0; n_sub = 2'd1;
                        end else begin
                            n_scl = 1'b1;
                            n_shift = {r_shift[6:0], 1'b0};
                            n_bits = r_bits + 4'd1;
                            if (r_bits >= 4'd7) begin
                                n_base = B_ACK; n_sub = 2'd0; n_timer = '0;
                            end else begin
                                n_sub = 2'd0;
                            end
                        end
                    end
                    B_ACK: begin
                        n_sda = 1'b1;
                        if (r_sub == 2'd0) begin
                            n_scl = 1'b0; n_sub = 2'd1;
                        end else begin
                            n_scl = 1'b1;
                            if (!i_cmd.sda_in) begin
                                n_sub = 2'd0;
                                case (r_kind)
                                    K_ADDRW: begin
                                        n_base = B_TX; n_kind = K_REG;
                                        n_shift = r_reg; n_bits = '0;
                                    end
                                    K_REG: begin
                                        n_kind = K_ADDRW;
                                        if (r_mode[0]) begin
                                            n_base = B_START; n_kind = K_REG;
                                        end else if (r_left != 8'd0) begin
                                            n_base = B_WAIT; n_kind = K_DATA;
                                        end else begin
                                            n_base = B_STOP;
                                        end
                                    end
                                    K_ADDRR: begin
                                        n_base = B_RX; n_kind = K_ADDRW;
                                        n_shift = '0; n_bits = '0;
                                    end
                                    default: begin
                                        n_left = left_dec;
                                        if (left_dec != 8'd0) begin
                                            n_base = B_WAIT; n_kind = K_DATA;
                                        end else begin
                                            n_base = B_STOP; n_kind = K_ADDRW;
                                        end
                                    end
                                endcase
                            end else begin
                                n_timer = timer_inc;
                                if (timer_inc == r_timeout) begin
                                    n_base = B_STOP; n_kind = K_REG; n_sub = 2'd0;
                                end
                            end
                        end
                    end
                    B_WAIT: begin
                        if (r_pend[8]) begin
                            n_shift = r_pend[7:0]; n_pend = '0; n_bits = '0;
                            n_scl = 1'b0; n_sda = r_pend[7];
                            n_base = B_TX; n_kind = K_DATA; n_sub = 2'd1;
                        end
                    end
                    B_RX: begin
                        n_sda = 1'b1;
                        if (r_sub == 2'd0) begin
                            n_scl = 1'b0; n_sub = 2'd1;
                        end else begin
                            n_scl = 1'b1;
                            n_shift = {r_shift[6:0], i_cmd.sda_in};
                            n_bits = r_bits + 4'd1;
                            n_sub = 2'd0;
                            if (r_bits >= 4'd7) begin
                                n_res.rx_byte = {r_shift[6:0], i_cmd.sda_in};
                                n_res.rx_valid = 1'b1;
                                n_base = B_RXACK; n_kind = K_ADDRW;
                            end
                        end
                    end
                    B_RXACK: begin
                        n_sda = (r_left <= 8'd1);
                        if (r_sub == 2'd0) begin
                            n_scl = 1'b0; n_sub = 2'd1;
                        end else begin
                            n_scl = 1'b1; n_left = left_dec;
                            n_sub = 2'd0; n_kind = K_ADDRW;
                            if (left_dec == 8'd0) begin
                                n_base = B_STOP;
                            end else begin
                                n_base = B_RX; n_shift = '0; n_bits = '0;
                            end
                        end
                    end
                    B_STOP: begin
                        case (r_sub)
                            2'd0: begin n_scl = 1'b0; n_sda = 1'b0; n_sub = 2'd1; end
                            2'd1: begin n_scl = 1'b1; n_sda = 1'b0; n_sub = 2'd2; end
                            default: begin
                                n_scl = 1'b1; n_sda = 1'b1;
                                n_res.failed  = r_kind[0];
                                n_res.done_ok = !r_kind[0];
                                n_base = B_IDLE; n_kind = K_ADDRW; n_sub = 2'd0;
                            end
                        endcase
                    end
                    default: begin
                        n_scl = 1'b1; n_sda = 1'b1;
                    end
                endcase
            end
        endcase
        n_res.scl = n_scl;
        n_res.sda = n_sda;
        n_res.want_data = (n_base == B_WAIT) && !n_pend[8];
        n_res.busy = (n_base != B_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= n_res;
        end
        if (!i_rst_n) begin
            r_timeout <= 16'(ACK_TIMEOUT_RESET);
            r_base <= B_IDLE; r_kind <= K_ADDRW; r_sub <= '0; r_bits <= '0;
            r_shift <= '0; r_left <= '0; r_timer <= '0; r_dev <= '0;
            r_reg <= '0; r_mode <= '0; r_pend <= '0;
            r_scl <= 1'b1; r_sda <= 1'b1; r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_data;
            end
            if (take) begin
                r_base <= n_base; r_kind <= n_kind; r_sub <= n_sub;
                r_bits <= n_bits; r_shift <= n_shift; r_left <= n_left;
                r_timer <= n_timer; r_dev <= n_dev; r_reg <= n_reg;
                r_mode <= n_mode; r_pend <= n_pend;
                r_scl <= n_scl; r_sda <= n_sda;
            end
            if (o_ready) begin
                r_ovalid <= take;
            end
        end
    end
endmodule

@@ design/i2c_master_transaction_engine.sv @@
// channel | dir | tdata fields (low bit up)                                      | tuser
// s_axis  | in  | opcode, dev_addr, sub_addr, length, use_reg, data_byte, sda_in | -
// m_axis  | out | scl_level, sda_level, rx_byte, rx_valid, want_data, done_ok,   | -
//         |     | failed, busy_res                                               |
// cfg     | in  | ack_timeout (16 bit), write enable                             | -
// One beat in and one result beat out per clock while m_axis accepts; a result beat
// passes the input register, the queue and the result register before it is valid.
// The bus sequencer in the back end handles one beat per cycle while m_axis
// does not stall it. Synchronous active-low reset returns to idle with both
// lines released. Back pressure on m_axis stalls the sequencer; the queue and
// input register absorb it so s_axis stalls only when they fill.
module i2c_master_transaction_engine import i2cm_pkg::*; #(
    parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // opcode, dev_addr, sub_addr, length, use_reg, data_byte, sda_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // scl, sda, rx_byte, rx_valid, want_data, done_ok, failed, busy
);
    logic fr_valid, fr_ready, q_valid, q_ready;
    t_cmd fr_cmd, q_cmd;
    logic [CMD_W-1:0] q_raw;
    t_res res;

    i2cm_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_data(s_axis_tdata),
        .o_valid(fr_valid), .i_ready(fr_ready), .o_cmd(fr_cmd)
    );

    i2cm_queue #(.WIDTH(CMD_W), .DEPTH(QDEPTH)) u_queue (
        .i_clk, .i_rst_n,
        .i_wr_valid(fr_valid), .o_wr_ready(fr_ready), .i_wr_data(fr_cmd),
        .o_rd_valid(q_valid), .i_rd_ready(q_ready), .o_rd_data(q_raw)
    );
    assign q_cmd = t_cmd'(q_raw);

    i2cm_back u_back (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_data,
        .i_valid(q_valid), .o_ready(q_ready), .i_cmd(q_cmd),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(res)
    );

    assign m_axis_tdata = {1'b0, res.busy, res.failed, res.done_ok, res.want_data,
                           res.rx_valid, res.rx_byte, res.sda, res.scl};
endmodule

@@ tb/i2c_master_transaction_engine_test.sv @@
module i2c_master_transaction_engine_test;
    import i2cm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned ITEMS_PER_PHASE = 240;

    // bus step of the sequencer
    typedef enum logic [2:0] {
        ST_IDLE, ST_START, ST_SEND, ST_ACK, ST_WAIT, ST_RECV, ST_MACK, ST_STOP
    } t_step;

    // what the byte in flight is
    localparam logic [1:0] KIND_ADDRW = 2'd0;
    localparam logic [1:0] KIND_REG   = 2'd1;
    localparam logic [1:0] KIND_ADDRR = 2'd2;
    localparam logic [1:0] KIND_DATA  = 2'd3;

    // one row of the directed plan, sent reps times
    typedef struct {
        t_opcode     op;
        logic [6:0]  dev;
        logic [7:0]  regad;
        logic [7:0]  len;
        logic        use_reg;
        logic [7:0]  data;
        logic        sda;
        int unsigned reps;
        bit          typed;
        logic [15:0] want_res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // opcode, dev_addr, sub_addr, length, use_reg, data_byte, sda_in
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // scl, sda, rx_byte, rx_valid, want_data, done_ok, failed, busy

    i2c_master_transaction_engine DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // bus sequencer mirror
    t_step       bstate;
    logic [1:0]  bkind;
    logic [2:0]  sub;
    logic [3:0]  bitcnt;
    logic [7:0]  shreg;
    logic [7:0]  left;
    logic [15:0] atimer;
    logic [15:0] ack_limit;
    logic [6:0]  sdev;
    logic [7:0]  sreg;
    logic        rd_mode;
    logic        with_reg;
    logic [8:0]  pend;
    logic        line_scl;
    logic        line_sda;

    logic [15:0] bus_results [$];
    int unsigned errors;
    int unsigned sent;
    int unsigned tx_idle_pct;
    int unsigned rx_stall_pct;
    bit          hold_req;
    int unsigned hold_left;
    int unsigned quiet_cycles;
    t_row        plan [6];

    function void go_step(t_step s, logic [1:0] k, logic [2:0] ss);
        bstate = s;
        bkind  = k;
        sub    = ss;
    endfunction

    function void load_byte(logic [1:0] k, logic [7:0] b);
        go_step(ST_SEND, k, 3'd0);
        shreg  = b;
        bitcnt = 4'd0;
    endfunction

    function void ack_seen();
        case (bkind)
            KIND_ADDRW: load_byte(KIND_REG, sreg);
            KIND_REG: begin
                if (rd_mode) go_step(ST_START, KIND_REG, 3'd0);
                else if (left != 0) go_step(ST_WAIT, KIND_DATA, 3'd0);
                else go_step(ST_STOP, KIND_ADDRW, 3'd0);
            end
            KIND_ADDRR: begin
                go_step(ST_RECV, KIND_ADDRW, 3'd0);
                shreg  = 8'd0;
                bitcnt = 4'd0;
            end
            default: begin
                left = left - 8'd1;
                if (left != 0) go_step(ST_WAIT, KIND_DATA, 3'd0);
                else go_step(ST_STOP, KIND_ADDRW, 3'd0);
            end
        endcase
    endfunction

    // advance the mirror by one beat and return the expected result beat
    function logic [15:0] bus_step(logic [39:0] d);
        t_opcode    op;
        logic       sin;
        logic       scl;
        logic       sda;
        logic [7:0] rxb;
        logic       rxv;
        logic       okf;
        logic       failf;
        logic       want;
        op    = t_opcode'(d[1:0]);
        sin   = d[34];
        scl   = line_scl;
        sda   = line_sda;
        rxb   = 8'd0;
        rxv   = 1'b0;
        okf   = 1'b0;
        failf = 1'b0;
        if (op == OP_WRITE || op == OP_READ) begin
            if (bstate == ST_IDLE) begin
                sdev = d[8:2];
                sreg = d[16:9];
                if (op == OP_READ) begin
                    rd_mode  = 1'b1;
                    with_reg = d[25];
                    left     = (d[24:17] == 0) ? 8'd1 : d[24:17];
                end else begin
                    rd_mode  = 1'b0;
                    with_reg = 1'b0;
                    left     = d[24:17];
                end
                pend = 9'd0;
                go_step(ST_START, KIND_ADDRW, 3'd1);
            end
        end else if (op == OP_DATA) begin
            if (bstate == ST_WAIT && !pend[8]) pend = {1'b1, d[33:26]};
        end else begin
            case (bstate)
                ST_START: begin
                    if (sub == 0) begin
                        scl = 0; sda = 1; sub = 1;
                    end else if (sub == 1) begin
                        scl = 1; sda = 1; sub = 2;
                    end else if (sub == 2) begin
                        scl = 1; sda = 0; sub = 3;
                    end else begin
                        scl = 0; sda = 0;
                        if (bkind == KIND_REG || (rd_mode && !with_reg))
                            load_byte(KIND_ADDRR, {sdev, 1'b1});
                        else
                            load_byte(KIND_ADDRW, {sdev, 1'b0});
                    end
                end
                ST_SEND: begin
                    sda = shreg[7];
                    if (sub == 0) begin
                        scl = 0; sub = 1;
                    end else begin
                        scl    = 1;
                        shreg  = shreg << 1;
                        bitcnt = bitcnt + 4'd1;
                        if (bitcnt >= 8) begin
                            go_step(ST_ACK, bkind, 3'd0);
                            atimer = 16'd0;
                        end else sub = 0;
                    end
                end
                ST_ACK: begin
                    sda = 1;
                    if (sub == 0) begin
                        scl = 0; sub = 1;
                    end else begin
                        scl = 1;
                        if (!sin) ack_seen();
                        else begin
                            atimer = atimer + 16'd1;
                            if (atimer == ack_limit) go_step(ST_STOP, KIND_REG, 3'd0);
                        end
                    end
                end
                ST_WAIT: begin
                    if (pend[8]) begin
                        shreg  = pend[7:0];
                        pend   = 9'd0;
                        bitcnt = 4'd0;
                        scl    = 0;
                        sda    = shreg[7];
                        go_step(ST_SEND, KIND_DATA, 3'd1);
                    end
                end
                ST_RECV: begin
                    sda = 1;
                    if (sub == 0) begin
                        scl = 0; sub = 1;
                    end else begin
                        scl    = 1;
                        shreg  = {shreg[6:0], sin};
                        bitcnt = bitcnt + 4'd1;
                        if (bitcnt >= 8) begin
                            rxb = shreg;
                            rxv = 1;
                            go_step(ST_MACK, KIND_ADDRW, 3'd0);
                        end else sub = 0;
                    end
                end
                ST_MACK: begin
                    sda = (left <= 1);
                    if (sub == 0) begin
                        scl = 0; sub = 1;
                    end else begin
                        scl  = 1;
                        left = left - 8'd1;
                        if (left == 0) go_step(ST_STOP, KIND_ADDRW, 3'd0);
                        else begin
                            go_step(ST_RECV, KIND_ADDRW, 3'd0);
                            shreg  = 8'd0;
                            bitcnt = 4'd0;
                        end
                    end
                end
                ST_STOP: begin
                    if (sub == 0) begin
                        scl = 0; sda = 0; sub = 1;
                    end else if (sub == 1) begin
                        scl = 1; sda = 0; sub = 2;
                    end else begin
                        scl = 1; sda = 1;
                        if (bkind[0]) failf = 1; else okf = 1;
                        go_step(ST_IDLE, KIND_ADDRW, 3'd0);
                    end
                end
                default: begin
                    scl = 1; sda = 1;
                end
            endcase
            line_scl = scl;
            line_sda = sda;
        end
        want = (bstate == ST_WAIT) && !pend[8];
        return {1'b0, bstate != ST_IDLE, failf, okf, want, rxv, rxb, sda, scl};
    endfunction

    function logic [39:0] pack_beat(t_opcode op, logic [6:0] dev, logic [7:0] regad,
                                    logic [7:0] len, logic use_reg, logic [7:0] data,
                                    logic sda);
        return {5'd0, sda, data, use_reg, len, regad, dev, op};
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, field, got, want);
        errors++;
    endtask

    task automatic compare_beat(logic [15:0] got, logic [15:0] want);
        if (got[0] !== want[0]) report_mismatch("scl_level", got[0], want[0]);
        if (got[1] !== want[1]) report_mismatch("sda_level", got[1], want[1]);
        if (got[9:2] !== want[9:2]) report_mismatch("rx_byte", got[9:2], want[9:2]);
        if (got[10] !== want[10]) report_mismatch("rx_valid", got[10], want[10]);
        if (got[11] !== want[11]) report_mismatch("want_data", got[11], want[11]);
        if (got[12] !== want[12]) report_mismatch("done_ok", got[12], want[12]);
        if (got[13] !== want[13]) report_mismatch("failed", got[13], want[13]);
        if (got[14] !== want[14]) report_mismatch("busy_res", got[14], want[14]);
    endtask

    // offer one beat, with an optional gap first; record the expectation on accept
    task automatic send_beat(logic [39:0] d, bit typed, logic [15:0] typed_res);
        int unsigned gap;
        logic [15:0] res;
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        do @(posedge i_clk); while (!s_axis_tready);
        res = bus_step(d);
        bus_results.push_back(typed ? typed_res : res);
        sent++;
    endtask

    // register writes only once the engine has drained
    task automatic write_timeout(logic [15:0] v);
        s_axis_tvalid <= 1'b0;
        while (bus_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        ack_limit = v;
    endtask

    // one command with ticks, data bytes and some noise until back to idle
    task automatic run_transfer();
        t_opcode     op;
        logic [7:0]  len;
        logic        sda;
        int unsigned r;
        op  = ($urandom_range(0, 1) != 0) ? OP_READ : OP_WRITE;
        len = ($urandom_range(0, 99) < 3) ? 8'($urandom_range(5, 40))
                                          : 8'($urandom_range(0, 3));
        send_beat(pack_beat(op, 7'($urandom), 8'($urandom), len, 1'($urandom),
                            8'($urandom), 1'($urandom)), 1'b0, 16'd0);
        while (bstate != ST_IDLE) begin
            r = $urandom_range(0, 99);
            if (bstate == ST_ACK && sub == 1) sda = ($urandom_range(0, 99) < 15);
            else sda = 1'($urandom);
            if (r < 4)
                send_beat(pack_beat(t_opcode'($urandom_range(0, 3)), 7'($urandom),
                                    8'($urandom), 8'($urandom), 1'($urandom),
                                    8'($urandom), 1'($urandom)), 1'b0, 16'd0);
            else if (bstate == ST_WAIT && !pend[8] && r < 75)
                send_beat(pack_beat(OP_DATA, 7'($urandom), 8'($urandom), 8'($urandom),
                                    1'($urandom), 8'($urandom), sda), 1'b0, 16'd0);
            else
                send_beat(pack_beat(OP_TICK, 7'($urandom), 8'($urandom), 8'($urandom),
                                    1'($urandom), 8'($urandom), sda), 1'b0, 16'd0);
        end
    endtask

    // long receiver hold-off, counted in cycles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_req) begin
            hold_left <= 400;
            hold_req = 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result side: compare, drive tready, watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (s_axis_tvalid && s_axis_tready) quiet_cycles = 0;
            if (m_axis_tvalid && m_axis_tready) begin
                quiet_cycles = 0;
                if (bus_results.size() == 0) begin
                    report_mismatch("unexpected beat", m_axis_tdata, 0);
                end else begin
                    compare_beat(m_axis_tdata, bus_results.pop_front());
                end
            end
            if (hold_left != 0) begin
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        int unsigned tx_pcts [5];
        int unsigned rx_pcts [5];
        logic [15:0] limits  [5];
        tx_pcts = '{0, 56, 0, 37, 0};
        rx_pcts = '{0, 0, 56, 37, 0};
        limits  = '{16'd65535, 16'd3, 16'd1024, 16'd2, 16'd1};
        errors = 0;
        sent = 0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        hold_req = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = 16'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 40'd0;

        // mirror reset state
        go_step(ST_IDLE, KIND_ADDRW, 3'd0);
        bitcnt = 0; shreg = 0; left = 0; atimer = 0; sdev = 0; sreg = 0;
        rd_mode = 0; with_reg = 0; pend = 0; line_scl = 1; line_sda = 1;
        ack_limit = 16'(ACK_TIMEOUT_RESET);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: idle items, busy commands, longest write aborted on first high ack
        plan[0] = '{OP_TICK,  7'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1,  1'b1, 16'h0003};
        plan[1] = '{OP_DATA,  7'h00, 8'h00, 8'h00, 1'b0, 8'hFF, 1'b1, 1,  1'b1, 16'h0003};
        plan[2] = '{OP_WRITE, 7'h7F, 8'hFF, 8'hFF, 1'b1, 8'h00, 1'b0, 1,  1'b1, 16'h4003};
        plan[3] = '{OP_READ,  7'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1,  1'b1, 16'h4003};
        plan[4] = '{OP_TICK,  7'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b1, 23, 1'b0, 16'h0000};
        plan[5] = '{OP_TICK,  7'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b1, 1,  1'b1, 16'h2003};
        write_timeout(16'd1);
        foreach (plan[i])
            repeat (plan[i].reps)
                send_beat(pack_beat(plan[i].op, plan[i].dev, plan[i].regad, plan[i].len,
                                    plan[i].use_reg, plan[i].data, plan[i].sda),
                          plan[i].typed, plan[i].want_res);

        // random transfers, one idling mix and timeout per phase
        for (int p = 0; p < 5; p++) begin
            write_timeout(limits[p]);
            tx_idle_pct  = tx_pcts[p];
            rx_stall_pct = rx_pcts[p];
            if (p == 4) hold_req = 1'b1;
            while (sent < ITEMS_PER_PHASE * (p + 1)) run_transfer();
        end

        s_axis_tvalid <= 1'b0;
        while (bus_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
